// ===== hdl/bis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear scaler package
// Shared sizes, register indexes, pixel types and the frame address function.
// ----------------------------------------------------------------------------
package bis_pkg;

	// Frame store geometry and blend precision.
	localparam int MAX_WIDTH     = 256;
	localparam int MAX_HEIGHT    = 256;
	localparam int FRACTION_BITS = 8;

	// Fixed field widths.
	localparam int COORD_W     = 12;
	localparam int CH_W        = 8;
	localparam int NUM_CH      = 3;
	localparam int CFG_SIZE_W  = 9;
	localparam int CFG_SCALE_W = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int SCALE_FRAC  = 8;

	// Derived widths.
	localparam int X_W       = $clog2(MAX_WIDTH);
	localparam int Y_W       = $clog2(MAX_HEIGHT);
	localparam int RAM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W    = $clog2(RAM_DEPTH);
	localparam int PROD_W    = COORD_W + CFG_SCALE_W;
	localparam int IDX_W     = PROD_W - SCALE_FRAC;
	localparam int WGT_W     = FRACTION_BITS + 1;
	localparam int H_W       = CH_W + FRACTION_BITS;
	localparam int ACC_W     = CH_W + 2 * FRACTION_BITS + 1;

	localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRACTION_BITS;

	// Opcodes of an input word.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE = 2'd2;

	// Channel positions inside a packed pixel.
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

	// Clamped neighbour coordinates and blend weights of one output pixel.
	typedef struct packed {
		logic [X_W-1:0]           x1;
		logic [X_W-1:0]           x2;
		logic [Y_W-1:0]           y1;
		logic [Y_W-1:0]           y2;
		logic [FRACTION_BITS-1:0] dx;
		logic [FRACTION_BITS-1:0] dy;
	} nbr_t;

	function automatic logic [ADDR_W-1:0] pix_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
		return ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(x);
	endfunction

endpackage

// ===== hdl/bis_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear scaler input channel
// Valid/ready channel carrying pixel write and pixel read words.
// ----------------------------------------------------------------------------
interface bis_in_if;
	import bis_pkg::*;

	logic               valid;
	logic               ready;
	logic               opcode;
	logic [COORD_W-1:0] coord_x;
	logic [COORD_W-1:0] coord_y;
	logic [CH_W-1:0]    in_red;
	logic [CH_W-1:0]    in_green;
	logic [CH_W-1:0]    in_blue;

	modport source (
		output valid, opcode, coord_x, coord_y, in_red, in_green, in_blue,
		input  ready
	);

	modport sink (
		input  valid, opcode, coord_x, coord_y, in_red, in_green, in_blue,
		output ready
	);

endinterface

// ===== hdl/bis_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear scaler output channel
// Valid/ready channel carrying interpolated RGB words.
// ----------------------------------------------------------------------------
interface bis_out_if;
	import bis_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;

	modport source (
		output valid, out_red, out_green, out_blue,
		input  ready
	);

	modport sink (
		input  valid, out_red, out_green, out_blue,
		output ready
	);

endinterface

// ===== hdl/bis_frame_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear scaler frame memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bis_frame_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [bis_pkg::ADDR_W-1:0] waddr,
	input  bis_pkg::rgb_t              wdata,
	input  logic                       re,
	input  logic [bis_pkg::ADDR_W-1:0] raddr,
	output bis_pkg::rgb_t              rdata
);
	import bis_pkg::*;

	rgb_t mem [RAM_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/bis_coord_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear scaler coordinate mapper
// Scales an output coordinate back to the source and clamps the neighbours.
// ----------------------------------------------------------------------------
module bis_coord_map (
	input  logic                            clk,
	input  logic                            en1,
	input  logic                            en2,
	input  logic [bis_pkg::COORD_W-1:0]     cx,
	input  logic [bis_pkg::COORD_W-1:0]     cy,
	input  logic [bis_pkg::CFG_SIZE_W-1:0]  src_width,
	input  logic [bis_pkg::CFG_SIZE_W-1:0]  src_height,
	input  logic [bis_pkg::CFG_SCALE_W-1:0] inv_scale,
	output bis_pkg::nbr_t                   nbr
);
	import bis_pkg::*;

	logic [PROD_W-1:0] px_s1, py_s1;
	logic [X_W-1:0]    xmax_d, xmax_s1;
	logic [Y_W-1:0]    ymax_d, ymax_s1;
	logic [IDX_W-1:0]  xi, yi;
	logic [SCALE_FRAC+FRACTION_BITS-1:0] fx_ext, fy_ext;
	nbr_t              nbr_d;

	// Largest valid index; a zero size counts as one, an oversize as the store.
	always_comb begin
		if (src_width == '0) begin
			xmax_d = '0;
		end else if (32'(src_width) > MAX_WIDTH) begin
			xmax_d = X_W'(MAX_WIDTH - 1);
		end else begin
			xmax_d = X_W'(src_width - 1'b1);
		end
		if (src_height == '0) begin
			ymax_d = '0;
		end else if (32'(src_height) > MAX_HEIGHT) begin
			ymax_d = Y_W'(MAX_HEIGHT - 1);
		end else begin
			ymax_d = Y_W'(src_height - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1   <= PROD_W'(cx) * PROD_W'(inv_scale);
			py_s1   <= PROD_W'(cy) * PROD_W'(inv_scale);
			xmax_s1 <= xmax_d;
			ymax_s1 <= ymax_d;
		end
	end

	always_comb begin
		xi = px_s1[PROD_W-1:SCALE_FRAC];
		yi = py_s1[PROD_W-1:SCALE_FRAC];

		nbr_d.x2 = (xi >= IDX_W'(xmax_s1)) ? xmax_s1 : X_W'(xi) + X_W'(1);
		nbr_d.x1 = (xi >  IDX_W'(xmax_s1)) ? xmax_s1 : X_W'(xi);
		nbr_d.y2 = (yi >= IDX_W'(ymax_s1)) ? ymax_s1 : Y_W'(yi) + Y_W'(1);
		nbr_d.y1 = (yi >  IDX_W'(ymax_s1)) ? ymax_s1 : Y_W'(yi);

		// Requantize the 8-bit source fraction to the blend weight width.
		fx_ext   = {px_s1[SCALE_FRAC-1:0], {FRACTION_BITS{1'b0}}} >> SCALE_FRAC;
		fy_ext   = {py_s1[SCALE_FRAC-1:0], {FRACTION_BITS{1'b0}}} >> SCALE_FRAC;
		nbr_d.dx = fx_ext[FRACTION_BITS-1:0];
		nbr_d.dy = fy_ext[FRACTION_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			nbr <= nbr_d;
		end
	end

endmodule

// ===== hdl/bis_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear scaler blend unit
// Two-stage separable blend: horizontal pairs first, then vertical.
// ----------------------------------------------------------------------------
module bis_blend (
	input  logic                                clk,
	input  logic                                en1,
	input  logic                                en2,
	input  bis_pkg::rgb_t                       q11,
	input  bis_pkg::rgb_t                       q21,
	input  bis_pkg::rgb_t                       q12,
	input  bis_pkg::rgb_t                       q22,
	input  logic [bis_pkg::FRACTION_BITS-1:0]   dx,
	input  logic [bis_pkg::FRACTION_BITS-1:0]   dy,
	output bis_pkg::rgb_t                       rgb
);
	import bis_pkg::*;

	logic [WGT_W-1:0]              wdx, wdx_n, wdy, wdy_n;
	logic [NUM_CH-1:0][H_W:0]      top_sum, bot_sum;
	logic [NUM_CH-1:0][H_W-1:0]    top_s1, bot_s1;
	logic [FRACTION_BITS-1:0]      dy_s1;
	logic [NUM_CH-1:0][ACC_W-1:0]  acc;
	rgb_t                          rgb_d;

	always_comb begin
		wdx   = WGT_W'(dx);
		wdx_n = WGT_ONE - wdx;
		for (int c = 0; c < NUM_CH; c++) begin
			top_sum[c] = (H_W+1)'(q11[c]) * (H_W+1)'(wdx_n)
			           + (H_W+1)'(q21[c]) * (H_W+1)'(wdx);
			bot_sum[c] = (H_W+1)'(q12[c]) * (H_W+1)'(wdx_n)
			           + (H_W+1)'(q22[c]) * (H_W+1)'(wdx);
		end
	end

	// A weighted pair never exceeds 255 * one, so the top bit is always zero.
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int c = 0; c < NUM_CH; c++) begin
				top_s1[c] <= top_sum[c][H_W-1:0];
				bot_s1[c] <= bot_sum[c][H_W-1:0];
			end
			dy_s1 <= dy;
		end
	end

	always_comb begin
		wdy   = WGT_W'(dy_s1);
		wdy_n = WGT_ONE - wdy;
		for (int c = 0; c < NUM_CH; c++) begin
			acc[c]   = ACC_W'(top_s1[c]) * ACC_W'(wdy_n) + ACC_W'(bot_s1[c]) * ACC_W'(wdy);
			rgb_d[c] = acc[c][2*FRACTION_BITS +: CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			rgb <= rgb_d;
		end
	end

endmodule

// ===== hdl/bilinear_image_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler
// Holds one RGB source frame and returns bilinearly interpolated pixels.
// ----------------------------------------------------------------------------
// A pixel write word leaves the sequencer idle for the next word. A pixel read
// word passes through the mapping, fetch, blend and output states; the next
// word is taken once its result has gone into the output register. The four
// neighbour reads go one after another through the single read port of the
// frame memory. Reset clears the sequencer and the output valid flag and sets
// the registers to 256 x 256 and unity scale; the frame memory is not cleared.
// ----------------------------------------------------------------------------
module bilinear_image_scaler (
	input  logic                           clk,
	input  logic                           arst_n,
	bis_in_if.sink                         pix_in,
	bis_out_if.source                      pix_out,
	input  logic                           cfg_we,
	input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bis_pkg::*;

	// Sequencer for one read word: map the coordinate, fetch the four
	// neighbours, blend, then hand the result to the output register.
	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_MAP  = 10'b00_0000_0010,
		S_RD0  = 10'b00_0000_0100,
		S_RD1  = 10'b00_0000_1000,
		S_RD2  = 10'b00_0001_0000,
		S_RD3  = 10'b00_0010_0000,
		S_RDW  = 10'b00_0100_0000,
		S_BL1  = 10'b00_1000_0000,
		S_BL2  = 10'b01_0000_0000,
		S_OUT  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers. Writes must arrive only while the block is idle; the block does not enforce this.
	logic [CFG_SIZE_W-1:0]  width_q;
	logic [CFG_SIZE_W-1:0]  height_q;
	logic [CFG_SCALE_W-1:0] inv_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= CFG_SIZE_W'(256);
			height_q    <= CFG_SIZE_W'(256);
			inv_scale_q <= CFG_SCALE_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_WIDTH:  width_q     <= cfg_data[CFG_SIZE_W-1:0];
				REG_SOURCE_HEIGHT: height_q    <= cfg_data[CFG_SIZE_W-1:0];
				REG_INVERSE_SCALE: inv_scale_q <= cfg_data[CFG_SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Input handshake. Words are taken only between read operations, but a
	// pending result in the output register does not hold the input back.
	logic accept, rd_start, in_range;

	assign pix_in.ready = (state_q == S_IDLE);
	assign accept       = pix_in.valid && pix_in.ready;
	assign rd_start     = accept && (pix_in.opcode == OP_READ);
	assign in_range     = (32'(pix_in.coord_x) < MAX_WIDTH) &&
	                      (32'(pix_in.coord_y) < MAX_HEIGHT);

	// Frame memory. Writes outside the store are dropped; writes outside the
	// configured frame but inside the store are kept.
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	rgb_t              ram_wdata, ram_rdata;

	assign ram_we    = accept && (pix_in.opcode == OP_WRITE) && in_range;
	assign ram_waddr = pix_addr(X_W'(pix_in.coord_x), Y_W'(pix_in.coord_y));
	always_comb begin
		ram_wdata          = '0;
		ram_wdata[CH_RED]   = pix_in.in_red;
		ram_wdata[CH_GREEN] = pix_in.in_green;
		ram_wdata[CH_BLUE]  = pix_in.in_blue;
	end

	bis_frame_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Coordinate mapping: the multiply registers at acceptance, the clamped
	// neighbours register at the end of the mapping state.
	nbr_t nbr;

	bis_coord_map u_map (
		.clk        (clk),
		.en1        (rd_start),
		.en2        (state_q == S_MAP),
		.cx         (pix_in.coord_x),
		.cy         (pix_in.coord_y),
		.src_width  (width_q),
		.src_height (height_q),
		.inv_scale  (inv_scale_q),
		.nbr        (nbr)
	);

	// Neighbour fetch. Each read address is issued in its own state and its
	// data is taken one state later, when the memory output has settled.
	always_comb begin
		ram_re = 1'b0;
		case (state_q)
			S_RD0: begin
				ram_re    = 1'b1;
				ram_raddr = pix_addr(nbr.x1, nbr.y1);
			end
			S_RD1: begin
				ram_re    = 1'b1;
				ram_raddr = pix_addr(nbr.x2, nbr.y1);
			end
			S_RD2: begin
				ram_re    = 1'b1;
				ram_raddr = pix_addr(nbr.x1, nbr.y2);
			end
			S_RD3: begin
				ram_re    = 1'b1;
				ram_raddr = pix_addr(nbr.x2, nbr.y2);
			end
			default: begin
				ram_raddr = pix_addr(nbr.x1, nbr.y1);
			end
		endcase
	end

	rgb_t q11_q, q21_q, q12_q, q22_q;

	always_ff @(posedge clk) begin
		if (state_q == S_RD1) q11_q <= ram_rdata;
		if (state_q == S_RD2) q21_q <= ram_rdata;
		if (state_q == S_RD3) q12_q <= ram_rdata;
		if (state_q == S_RDW) q22_q <= ram_rdata;
	end

	// Blend of the four neighbours, all channels side by side.
	rgb_t blend_rgb;

	bis_blend u_blend (
		.clk (clk),
		.en1 (state_q == S_BL1),
		.en2 (state_q == S_BL2),
		.q11 (q11_q),
		.q21 (q21_q),
		.q12 (q12_q),
		.q22 (q22_q),
		.dx  (nbr.dx),
		.dy  (nbr.dy),
		.rgb (blend_rgb)
	);

	// Output register. The result waits in S_OUT until the register is free
	// or is being emptied in the same cycle.
	logic out_valid_q, out_load;
	rgb_t out_rgb_q;

	assign out_load = (state_q == S_OUT) && (!out_valid_q || pix_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rgb_q <= blend_rgb;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.out_red   = out_rgb_q[CH_RED];
	assign pix_out.out_green = out_rgb_q[CH_GREEN];
	assign pix_out.out_blue  = out_rgb_q[CH_BLUE];

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (rd_start) state_d = S_MAP;
			S_MAP:   state_d = S_RD0;
			S_RD0:   state_d = S_RD1;
			S_RD1:   state_d = S_RD2;
			S_RD2:   state_d = S_RD3;
			S_RD3:   state_d = S_RDW;
			S_RDW:   state_d = S_BL1;
			S_BL1:   state_d = S_BL2;
			S_BL2:   state_d = S_OUT;
			S_OUT:   if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A read word always starts the mapping step.
	a_read_starts_map: assert property (@(posedge clk) disable iff (!arst_n)
		rd_start |=> (state_q == S_MAP))
		else $error("read word did not start the mapping step");

	// A write word completes in its acceptance cycle.
	a_write_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (pix_in.opcode == OP_WRITE)) |=> (state_q == S_IDLE))
		else $error("write word left the sequencer busy");

	// Clamped neighbours are ordered and at most one pixel apart.
	a_nbr_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD0) |-> ((nbr.x1 <= nbr.x2) && (nbr.y1 <= nbr.y2) &&
		                        ((nbr.x2 - nbr.x1) <= X_W'(1)) &&
		                        ((nbr.y2 - nbr.y1) <= Y_W'(1))))
		else $error("neighbour coordinates out of order");

	// A new result appears only as the sequencer leaves the output state.
	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result loaded outside the output state");

endmodule
